[design/varint_stream_decoder_top_macros.svh]
// Assertion macros used by the varint stream decoder checker.
`ifndef VARINT_STREAM_DECODER_TOP_MACROS_SVH
`define VARINT_STREAM_DECODER_TOP_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define VSD_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Checks that the consequent holds in the same cycle as the antecedent.
`define VSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define VSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/vsd_pkg.sv]
// Types, codes and helpers shared by the varint stream decoder.
`default_nettype none
package vsd_pkg;

  localparam int unsigned VALUE_W   = 64;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // Register index codes.
  localparam logic REG_DECODE_MODE = 1'b0;

  // Decode modes; the unused code decodes like unsigned LEB128.
  localparam logic [1:0] MODE_LEB    = 2'd0;
  localparam logic [1:0] MODE_ZIGZAG = 2'd1;
  localparam logic [1:0] MODE_TAGGED = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TRUNCATED = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_BAD_TAG   = 2'd3;

  // Tagged-mode tag codes.
  localparam logic [7:0] TAG_DIRECT_MAX = 8'd250;
  localparam logic [7:0] TAG_BE2        = 8'd251;
  localparam logic [7:0] TAG_BE4        = 8'd252;
  localparam logic [7:0] TAG_BE8        = 8'd253;

  localparam logic [3:0] LEB_LAST_GROUP = 4'd9;
  localparam logic [5:0] LEB_GROUP_BITS = 6'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] decoded_value;
    logic [1:0]         status;
  } result_t;

  // Number of payload bytes that follow a tag; zero for tags without payload.
  function automatic logic [3:0] tag_payload_len(input logic [7:0] tag);
    logic [3:0] len;
    unique case (tag)
      TAG_BE2: len = 4'd2;
      TAG_BE4: len = 4'd4;
      TAG_BE8: len = 4'd8;
      default: len = 4'd0;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

[design/vsd_cfg.sv]
// APB register block holding the decode mode.
`default_nettype none
module vsd_cfg import vsd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [1:0]            mode_o,
  output logic                  restart_o
);

  logic [1:0] mode_q, mode_d;
  logic       wr_en;
  logic       reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_DECODE_MODE);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    mode_d = mode_q;
    if (wr_en && reg_hit) begin
      mode_d = pwdata[1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_LEB;
    end else begin
      mode_q <= mode_d;
    end
  end

  assign prdata    = reg_hit ? {{(APB_DATA_W-2){1'b0}}, mode_q} : '0;
  assign mode_o    = mode_q;
  // Any mode write drops a value in progress.
  assign restart_o = wr_en && reg_hit;

endmodule
`default_nettype wire

[design/vsd_in_reg.sv]
// Input register stage for incoming stream bytes.
`default_nettype none
module vsd_in_reg import vsd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  s_valid_i,
  output logic  s_ready_o,
  input  item_t item_i,
  input  logic  advance_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  accept;

  assign s_ready_o = !valid_q || advance_i;
  assign accept    = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

[design/vsd_step.sv]
// Decoder state and the per-byte LEB128 / tagged decode step.
`default_nettype none
module vsd_step import vsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic       restart_i,
  input  logic [1:0] mode_i,
  input  item_t      item_i,
  output logic       emit_o,
  output result_t    result_o
);

  logic [VALUE_W-1:0] acc_q, acc_d;
  logic [3:0]         cnt_q, cnt_d;
  logic               in_value_q, in_value_d;

  logic [7:0]         b;
  logic               last;
  logic [5:0]         shamt;
  logic [VALUE_W-1:0] acc_leb;
  logic [VALUE_W-1:0] acc_tag;
  logic [3:0]         tag_len;
  logic [3:0]         rem;
  logic               emit;
  logic [1:0]         status;
  logic [VALUE_W-1:0] value;

  assign b       = item_i.data_byte;
  assign last    = item_i.end_of_data;
  // cnt_q stays at or below the last group, so the shift is at most 63.
  assign shamt   = {2'b00, cnt_q} * LEB_GROUP_BITS;
  assign acc_leb = acc_q | (VALUE_W'(b[6:0]) << shamt);
  assign acc_tag = {acc_q[VALUE_W-9:0], b};
  assign tag_len = tag_payload_len(b);
  assign rem     = (cnt_q == 4'd0) ? 4'd0 : cnt_q - 4'd1;

  always_comb begin
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    in_value_d = in_value_q;
    emit       = 1'b0;
    status     = ST_OK;
    value      = '0;
    if (mode_i == MODE_TAGGED) begin
      if (!in_value_q) begin
        if (b <= TAG_DIRECT_MAX) begin
          emit  = 1'b1;
          value = VALUE_W'(b);
        end else if (tag_len != 4'd0) begin
          in_value_d = 1'b1;
          acc_d      = '0;
          cnt_d      = tag_len;
          if (last) begin
            emit   = 1'b1;
            status = ST_TRUNCATED;
          end
        end else begin
          emit   = 1'b1;
          status = ST_BAD_TAG;
        end
      end else begin
        if (rem == 4'd0) begin
          emit  = 1'b1;
          value = acc_tag;
        end else if (last) begin
          emit   = 1'b1;
          status = ST_TRUNCATED;
        end else begin
          acc_d = acc_tag;
          cnt_d = rem;
        end
      end
    end else begin
      if (!b[7]) begin
        emit = 1'b1;
        if (mode_i == MODE_ZIGZAG) begin
          value = (acc_leb >> 1) ^ {VALUE_W{acc_leb[0]}};
        end else begin
          value = acc_leb;
        end
      end else if (cnt_q == LEB_LAST_GROUP) begin
        // A continuation flag on the tenth byte cannot fit in 64 bits.
        emit   = 1'b1;
        status = ST_OVERFLOW;
      end else if (last) begin
        emit   = 1'b1;
        status = ST_TRUNCATED;
      end else begin
        acc_d = acc_leb;
        cnt_d = cnt_q + 4'd1;
      end
    end
    if (emit) begin
      acc_d      = '0;
      cnt_d      = 4'd0;
      in_value_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      cnt_q      <= 4'd0;
      in_value_q <= 1'b0;
    end else if (restart_i) begin
      acc_q      <= '0;
      cnt_q      <= 4'd0;
      in_value_q <= 1'b0;
    end else if (fire_i) begin
      acc_q      <= acc_d;
      cnt_q      <= cnt_d;
      in_value_q <= in_value_d;
    end
  end

  assign emit_o                 = emit;
  assign result_o.decoded_value = (status == ST_OK) ? value : '0;
  assign result_o.status        = status;

endmodule
`default_nettype wire

[design/vsd_out_reg.sv]
// Output register holding one decoded result until it is taken.
`default_nettype none
module vsd_out_reg import vsd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  logic    emit_i,
  input  result_t result_i,
  output logic    free_o,
  output logic    m_valid_o,
  input  logic    m_ready_i,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o = !valid_q || m_ready_i;

  always_comb begin
    if (load_i) begin
      valid_d = emit_i;
    end else begin
      valid_d = valid_q && !m_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && emit_i) begin
      res_q <= result_i;
    end
  end

  assign m_valid_o = valid_q;
  assign result_o  = res_q;

endmodule
`default_nettype wire

[design/varint_stream_decoder_top.sv]
// A byte goes from the input register through the decode step into the output
// register. Throughput: one byte per cycle while the output is not stalled.
// The input stage takes a new byte whenever the output register is free or drains.
// Reset is asynchronous and clears the mode to unsigned LEB128, the decode state
// and both valid flags; no clearing pass is needed after reset.
`default_nettype none
module varint_stream_decoder_top import vsd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,  // [7:0] data_byte
  input  logic                  s_axis_tlast,  // end_of_data
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [VALUE_W-1:0]    m_axis_tdata,  // [63:0] decoded_value
  output logic [1:0]            m_axis_tuser,  // [1:0] status
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic       mode_restart;
  logic [1:0] mode;
  item_t      in_item;
  item_t      stage_item;
  logic       stage_valid;
  logic       out_free;
  logic       advance;
  logic       emit;
  result_t    step_res;
  result_t    out_res;

  assign in_item.data_byte   = s_axis_tdata;
  assign in_item.end_of_data = s_axis_tlast;
  assign advance             = stage_valid && out_free;

  vsd_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .mode_o    (mode),
    .restart_o (mode_restart)
  );

  vsd_in_reg u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .item_i    (in_item),
    .advance_i (advance),
    .valid_o   (stage_valid),
    .item_o    (stage_item)
  );

  vsd_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (advance),
    .restart_i (mode_restart),
    .mode_i    (mode),
    .item_i    (stage_item),
    .emit_o    (emit),
    .result_o  (step_res)
  );

  vsd_out_reg u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (advance),
    .emit_i    (emit),
    .result_i  (step_res),
    .free_o    (out_free),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .result_o  (out_res)
  );

  assign m_axis_tdata = out_res.decoded_value;
  assign m_axis_tuser = out_res.status;

endmodule
`default_nettype wire

[design/vsd_checker.sv]
// Port-level checker for the varint stream decoder and its bind.
`default_nettype none
`include "varint_stream_decoder_top_macros.svh"
module vsd_checker import vsd_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [VALUE_W-1:0]    m_axis_tdata,
  input logic [1:0]            m_axis_tuser,
  input logic                  pready
);

  logic               out_stall;
  logic               out_err;
  logic [VALUE_W+1:0] out_word;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_err   = m_axis_tvalid && (m_axis_tuser != ST_OK);
  assign out_word  = {m_axis_tdata, m_axis_tuser};

  // A stalled result request keeps its payload.
  `VSD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(out_word))

  // Error results always carry a zero value.
  `VSD_ASSERT_IMPL(a_err_zero, clk_i, rst_ni, out_err, m_axis_tdata == '0)

  // With no result pending the input stage always drains, so it takes a byte.
  `VSD_ASSERT_IMPL(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)

  // The register port never inserts wait states.
  `VSD_ASSERT_ALWAYS(a_pready, clk_i, rst_ni, pready)

endmodule

bind varint_stream_decoder_top vsd_checker u_vsd_checker (.*);
`default_nettype wire
